FILE: rtl/core/q9sf_pkg.sv
package q9sf_pkg;

  localparam int FRAC_BITS = 14;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 18;
  localparam int NODE_W = 4;

  // Per-axis factor widths for a 16-bit coordinate at FRAC_BITS = 14:
  // |L * 2S^2| stays below 2^31, |L' * 2S| stays below 2^18.
  localparam int AX_W  = IN_W + 2;
  localparam int VAL_W = 32;
  localparam int DER_W = IN_W + 3;

  // Product widths: value x value, derivative x value
  localparam int PV_W = 2 * VAL_W;
  localparam int PD_W = VAL_W + DER_W;

  // Rounding shifts back to Q3.FRAC_BITS
  localparam int KV = 3 * FRAC_BITS + 2;
  localparam int KD = 2 * FRAC_BITS + 2;

  localparam logic [NODE_W-1:0] LAST_NODE = 4'd8;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

  localparam logic signed [AX_W-1:0]  ONE_AX  = 18'sd1 <<< FRAC_BITS;
  localparam logic signed [DER_W-1:0] ONE_DER = 19'sd1 <<< FRAC_BITS;

  // Which 1-D quadratic Lagrange polynomial an axis uses
  typedef enum logic [1:0] {
    SEL_MINUS = 2'd0,
    SEL_MID   = 2'd1,
    SEL_PLUS  = 2'd2
  } lag_sel_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;  // L(x) * 2*S^2
    logic signed [DER_W-1:0] der;  // L'(x) * 2*S
  } lag_t;

  function automatic lag_sel_t csi_sel(input logic [NODE_W-1:0] node);
    lag_sel_t s;
    case (node)
      4'd0, 4'd3, 4'd7: s = SEL_MINUS;
      4'd1, 4'd2, 4'd5: s = SEL_PLUS;
      default:          s = SEL_MID;
    endcase
    return s;
  endfunction

  function automatic lag_sel_t eta_sel(input logic [NODE_W-1:0] node);
    lag_sel_t s;
    case (node)
      4'd0, 4'd1, 4'd4: s = SEL_MINUS;
      4'd2, 4'd3, 4'd6: s = SEL_PLUS;
      default:          s = SEL_MID;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/q9sf_if.sv
interface q9sf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [q9sf_pkg::IN_W-1:0]  csi;
  logic signed [q9sf_pkg::IN_W-1:0]  eta;

  modport source (output valid, output csi, output eta, input ready);
  modport sink   (input valid, input csi, input eta, output ready);
endinterface

interface q9sf_out_if;
  logic                               valid;
  logic                               ready;
  logic [q9sf_pkg::NODE_W-1:0]        node;
  logic signed [q9sf_pkg::OUT_W-1:0]  shape_value;
  logic signed [q9sf_pkg::OUT_W-1:0]  d_dcsi;
  logic signed [q9sf_pkg::OUT_W-1:0]  d_deta;
  logic                               last;

  modport source (output valid, output node, output shape_value, output d_dcsi,
                  output d_deta, output last, input ready);
  modport sink   (input valid, input node, input shape_value, input d_dcsi,
                  input d_deta, input last, output ready);
endinterface

FILE: rtl/core/q9sf_lagrange.sv
module q9sf_lagrange (
  input  q9sf_pkg::lag_sel_t                sel,
  input  logic signed [q9sf_pkg::IN_W-1:0]  x,
  output q9sf_pkg::lag_t                    lag
);

  logic signed [q9sf_pkg::AX_W-1:0]    xe;
  logic signed [q9sf_pkg::AX_W-1:0]    op_a;
  logic signed [q9sf_pkg::AX_W-1:0]    op_b;
  logic signed [2*q9sf_pkg::AX_W-1:0]  prod;
  logic signed [2*q9sf_pkg::AX_W-1:0]  val_full;
  logic signed [q9sf_pkg::DER_W-1:0]   xd;

  always_comb begin
    xe = q9sf_pkg::AX_W'(x);
    xd = q9sf_pkg::DER_W'(x);
    case (sel)
      q9sf_pkg::SEL_MINUS: begin
        op_a    = xe;
        op_b    = xe - q9sf_pkg::ONE_AX;
        lag.der = (xd <<< 1) - q9sf_pkg::ONE_DER;
      end
      q9sf_pkg::SEL_PLUS: begin
        op_a    = xe;
        op_b    = xe + q9sf_pkg::ONE_AX;
        lag.der = (xd <<< 1) + q9sf_pkg::ONE_DER;
      end
      default: begin
        // middle polynomial 1 - x^2, carried as 2*(S-x)*(S+x)
        op_a    = q9sf_pkg::ONE_AX - xe;
        op_b    = q9sf_pkg::ONE_AX + xe;
        lag.der = -(xd <<< 2);
      end
    endcase
    prod     = op_a * op_b;
    val_full = (sel == q9sf_pkg::SEL_MINUS || sel == q9sf_pkg::SEL_PLUS) ? prod
                                                                         : (prod <<< 1);
    lag.val  = val_full[q9sf_pkg::VAL_W-1:0];
  end

endmodule

FILE: rtl/core/q9sf_round_sat.sv
module q9sf_round_sat #(
  parameter int IN_W  = 64,
  parameter int SHIFT = 44
) (
  input  logic signed [IN_W-1:0]            prod,
  output logic signed [q9sf_pkg::OUT_W-1:0] res
);

  localparam logic signed [IN_W-1:0] HALF   = IN_W'(1) << (SHIFT - 1);
  localparam logic signed [IN_W-1:0] SAT_HI = IN_W'(q9sf_pkg::OUT_MAX);
  localparam logic signed [IN_W-1:0] SAT_LO = IN_W'(q9sf_pkg::OUT_MIN);

  logic signed [IN_W-1:0] adj;
  logic signed [IN_W-1:0] shifted;

  // ties away from zero: negative values take half minus one, then floor
  always_comb begin
    adj     = prod + HALF - {{(IN_W-1){1'b0}}, prod[IN_W-1]};
    shifted = adj >>> SHIFT;
    if (shifted > SAT_HI) begin
      res = q9sf_pkg::OUT_MAX;
    end else if (shifted < SAT_LO) begin
      res = q9sf_pkg::OUT_MIN;
    end else begin
      res = shifted[q9sf_pkg::OUT_W-1:0];
    end
  end

endmodule

FILE: rtl/core/quad9_shape_function_eval_unit.sv
// Channel  Dir  Word                                            Handshake
// in_if    in   csi, eta (Q1.14)                                valid/ready
// out_if   out  node, shape_value, d_dcsi, d_deta (Q3.14), last valid/ready
//
// Nine node words per point leave one per cycle unless out_if stalls, the
// issue counter in the front stage setting that cadence; the next point is
// taken as the centre node issues. Stages: issue, factor, product, round.
// Reset clears the valid bits and the issue counter only.
// A stall on out_if backs up stage by stage; bubbles close up, nothing is lost.
module quad9_shape_function_eval_unit (
  input  logic        clk,
  input  logic        rst_n,
  q9sf_in_if.sink     in_if,
  q9sf_out_if.source  out_if
);

  // issue stage
  logic                                busy_r, busy_nxt;
  logic [q9sf_pkg::NODE_W-1:0]         node_r, node_nxt;
  logic signed [q9sf_pkg::IN_W-1:0]    csi_r;
  logic signed [q9sf_pkg::IN_W-1:0]    eta_r;

  // factor stage
  logic                                s1_v_r;
  logic [q9sf_pkg::NODE_W-1:0]         s1_node_r;
  q9sf_pkg::lag_t                      s1_csi_r;
  q9sf_pkg::lag_t                      s1_eta_r;

  // product stage
  logic                                s2_v_r;
  logic [q9sf_pkg::NODE_W-1:0]         s2_node_r;
  logic signed [q9sf_pkg::PV_W-1:0]    s2_pv_r;
  logic signed [q9sf_pkg::PD_W-1:0]    s2_pdc_r;
  logic signed [q9sf_pkg::PD_W-1:0]    s2_pde_r;

  // output register
  logic                                out_v_r;
  logic [q9sf_pkg::NODE_W-1:0]         out_node_r;
  logic signed [q9sf_pkg::OUT_W-1:0]   out_val_r;
  logic signed [q9sf_pkg::OUT_W-1:0]   out_dc_r;
  logic signed [q9sf_pkg::OUT_W-1:0]   out_de_r;
  logic                                out_last_r;

  logic                                s1_ready, s2_ready, s3_ready;
  logic                                issue, last_issue, in_acc;
  q9sf_pkg::lag_sel_t                  sel_c, sel_e;
  q9sf_pkg::lag_t                      lag_c, lag_e;
  logic signed [q9sf_pkg::PV_W-1:0]    pv_c;
  logic signed [q9sf_pkg::PD_W-1:0]    pdc_c;
  logic signed [q9sf_pkg::PD_W-1:0]    pde_c;
  logic signed [q9sf_pkg::OUT_W-1:0]   rv_c, rdc_c, rde_c;

  always_comb begin
    s3_ready   = !out_v_r || out_if.ready;
    s2_ready   = !s2_v_r || s3_ready;
    s1_ready   = !s1_v_r || s2_ready;
    issue      = busy_r && s1_ready;
    last_issue = issue && (node_r == q9sf_pkg::LAST_NODE);
  end

  // next point is taken in the cycle the centre node issues
  assign in_if.ready = !busy_r || last_issue;
  assign in_acc      = in_if.valid && in_if.ready;

  always_comb begin
    busy_nxt = busy_r;
    node_nxt = node_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
      node_nxt = '0;
    end else if (last_issue) begin
      busy_nxt = 1'b0;
    end else if (issue) begin
      node_nxt = node_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      node_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      node_r <= node_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      csi_r <= in_if.csi;
      eta_r <= in_if.eta;
    end
  end

  always_comb begin
    sel_c = q9sf_pkg::csi_sel(node_r);
    sel_e = q9sf_pkg::eta_sel(node_r);
  end

  q9sf_lagrange u_lag_csi (
    .sel (sel_c),
    .x   (csi_r),
    .lag (lag_c)
  );

  q9sf_lagrange u_lag_eta (
    .sel (sel_e),
    .x   (eta_r),
    .lag (lag_e)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_node_r <= node_r;
      s1_csi_r  <= lag_c;
      s1_eta_r  <= lag_e;
    end
  end

  always_comb begin
    pv_c  = s1_csi_r.val * s1_eta_r.val;
    pdc_c = s1_csi_r.der * s1_eta_r.val;
    pde_c = s1_csi_r.val * s1_eta_r.der;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_node_r <= s1_node_r;
      s2_pv_r   <= pv_c;
      s2_pdc_r  <= pdc_c;
      s2_pde_r  <= pde_c;
    end
  end

  q9sf_round_sat #(.IN_W(q9sf_pkg::PV_W), .SHIFT(q9sf_pkg::KV)) u_rnd_val (
    .prod (s2_pv_r),
    .res  (rv_c)
  );

  q9sf_round_sat #(.IN_W(q9sf_pkg::PD_W), .SHIFT(q9sf_pkg::KD)) u_rnd_dcsi (
    .prod (s2_pdc_r),
    .res  (rdc_c)
  );

  q9sf_round_sat #(.IN_W(q9sf_pkg::PD_W), .SHIFT(q9sf_pkg::KD)) u_rnd_deta (
    .prod (s2_pde_r),
    .res  (rde_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s3_ready) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      out_node_r <= s2_node_r;
      out_val_r  <= rv_c;
      out_dc_r   <= rdc_c;
      out_de_r   <= rde_c;
      out_last_r <= (s2_node_r == q9sf_pkg::LAST_NODE);
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.node        = out_node_r;
  assign out_if.shape_value = out_val_r;
  assign out_if.d_dcsi      = out_dc_r;
  assign out_if.d_deta      = out_de_r;
  assign out_if.last        = out_last_r;

endmodule

FILE: rtl/core/q9sf_checker.sv
module q9sf_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [q9sf_pkg::NODE_W-1:0]        out_node,
  input logic signed [q9sf_pkg::OUT_W-1:0]  out_shape_value,
  input logic signed [q9sf_pkg::OUT_W-1:0]  out_d_dcsi,
  input logic signed [q9sf_pkg::OUT_W-1:0]  out_d_deta,
  input logic                               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node) &&
      $stable(out_shape_value) && $stable(out_d_dcsi) && $stable(out_d_deta) &&
      $stable(out_last))
    else $error("result word changed while stalled");

  a_last_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_node == q9sf_pkg::LAST_NODE)))
    else $error("last flag does not match centre node");

  a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_node <= q9sf_pkg::LAST_NODE)
    else $error("node index out of range");

  // words of one point come out in node order, no gaps or repeats
  a_node_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) ##1 out_valid |->
      out_node == $past(out_node) + 4'd1)
    else $error("node sequence broken");

endmodule

bind quad9_shape_function_eval_unit q9sf_checker u_q9sf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_node        (out_if.node),
  .out_shape_value (out_if.shape_value),
  .out_d_dcsi      (out_if.d_dcsi),
  .out_d_deta      (out_if.d_deta),
  .out_last        (out_if.last)
);

FILE: test/tb_quad9_shape_function_eval_unit.sv
module tb_quad9_shape_function_eval_unit;

  typedef struct {
    logic [q9sf_pkg::NODE_W-1:0]       node;
    logic signed [q9sf_pkg::OUT_W-1:0] shape_value;
    logic signed [q9sf_pkg::OUT_W-1:0] d_dcsi;
    logic signed [q9sf_pkg::OUT_W-1:0] d_deta;
    logic                              last;
  } node_word_t;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_LONG_STALL
  } rx_mode_t;

  localparam q9sf_pkg::lag_sel_t CSI_FACTOR [9] = '{
    q9sf_pkg::SEL_MINUS, q9sf_pkg::SEL_PLUS, q9sf_pkg::SEL_PLUS, q9sf_pkg::SEL_MINUS,
    q9sf_pkg::SEL_MID, q9sf_pkg::SEL_PLUS, q9sf_pkg::SEL_MID, q9sf_pkg::SEL_MINUS,
    q9sf_pkg::SEL_MID};
  localparam q9sf_pkg::lag_sel_t ETA_FACTOR [9] = '{
    q9sf_pkg::SEL_MINUS, q9sf_pkg::SEL_MINUS, q9sf_pkg::SEL_PLUS, q9sf_pkg::SEL_PLUS,
    q9sf_pkg::SEL_MINUS, q9sf_pkg::SEL_MID, q9sf_pkg::SEL_PLUS, q9sf_pkg::SEL_MID,
    q9sf_pkg::SEL_MID};

  localparam logic signed [q9sf_pkg::IN_W-1:0] COORD_ONE  = 16'sd16384;
  localparam logic signed [q9sf_pkg::IN_W-1:0] COORD_HALF = 16'sd8192;
  localparam logic signed [q9sf_pkg::IN_W-1:0] COORD_MAX  = 16'sd32767;
  localparam logic signed [q9sf_pkg::IN_W-1:0] COORD_MIN  = -16'sd32768;

  logic clk;
  logic rst_n;

  q9sf_in_if  in_ch ();
  q9sf_out_if out_ch ();

  quad9_shape_function_eval_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  node_word_t  expected_words[$];
  int          error_count;
  int          points_sent;
  int          words_checked;
  int          saturated_words;
  int          burst_left;
  bit          sender_gaps;
  rx_mode_t    rx_mode;
  int unsigned stall_left;
  int unsigned run_left;

  always #6 clk = ~clk;

  // scaled by 2*S*S
  function automatic longint lagrange_value(q9sf_pkg::lag_sel_t sel, longint x);
    longint s;
    s = longint'(1) << q9sf_pkg::FRAC_BITS;
    case (sel)
      q9sf_pkg::SEL_MINUS: return x * (x - s);
      q9sf_pkg::SEL_PLUS:  return x * (x + s);
      default:             return 2 * (s - x) * (s + x);
    endcase
  endfunction

  // scaled by 2*S
  function automatic longint lagrange_slope(q9sf_pkg::lag_sel_t sel, longint x);
    longint s;
    s = longint'(1) << q9sf_pkg::FRAC_BITS;
    case (sel)
      q9sf_pkg::SEL_MINUS: return 2 * x - s;
      q9sf_pkg::SEL_PLUS:  return 2 * x + s;
      default:             return -4 * x;
    endcase
  endfunction

  // round half away from zero, then clamp to the 18-bit output range
  function automatic logic signed [q9sf_pkg::OUT_W-1:0] round_clamp(longint p, int k);
    longint mag;
    longint r;
    logic signed [q9sf_pkg::OUT_W-1:0] res;
    mag = (p < 0) ? -p : p;
    r = (mag + (longint'(1) << (k - 1))) >> k;
    if (p < 0) begin
      if (r > 131072) res = q9sf_pkg::OUT_MIN;
      else res = q9sf_pkg::OUT_W'(-r);
    end else begin
      if (r > 131071) res = q9sf_pkg::OUT_MAX;
      else res = q9sf_pkg::OUT_W'(r);
    end
    return res;
  endfunction

  task automatic predict_node_words(input logic signed [q9sf_pkg::IN_W-1:0] csi,
                                    input logic signed [q9sf_pkg::IN_W-1:0] eta);
    longint vc, ve, dc, de;
    node_word_t w;
    for (int n = 0; n < 9; n++) begin
      vc = lagrange_value(CSI_FACTOR[n], longint'(csi));
      ve = lagrange_value(ETA_FACTOR[n], longint'(eta));
      dc = lagrange_slope(CSI_FACTOR[n], longint'(csi));
      de = lagrange_slope(ETA_FACTOR[n], longint'(eta));
      w.node        = q9sf_pkg::NODE_W'(n);
      w.shape_value = round_clamp(vc * ve, q9sf_pkg::KV);
      w.d_dcsi      = round_clamp(dc * ve, q9sf_pkg::KD);
      w.d_deta      = round_clamp(vc * de, q9sf_pkg::KD);
      w.last        = (n == 8);
      expected_words.push_back(w);
    end
  endtask

  task automatic send_point(input logic signed [q9sf_pkg::IN_W-1:0] csi,
                            input logic signed [q9sf_pkg::IN_W-1:0] eta);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_gaps) gap = $urandom_range(0, 7);
    end
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      in_ch.csi   <= q9sf_pkg::IN_W'($urandom);
      in_ch.eta   <= q9sf_pkg::IN_W'($urandom);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.csi   <= csi;
    in_ch.eta   <= eta;
    do @(posedge clk); while (!in_ch.ready);
    predict_node_words(csi, eta);
    points_sent++;
    burst_left--;
  endtask

  // mostly interior points, biased toward node and half-node coordinates
  function automatic logic signed [q9sf_pkg::IN_W-1:0] interior_coord();
    int pick;
    int base;
    pick = $urandom_range(0, 9);
    base = (int'($urandom_range(0, 4)) - 2) * 8192;
    if (pick < 6) return q9sf_pkg::IN_W'(int'($urandom_range(0, 32768)) - 16384);
    if (pick < 8) begin
      base = base + int'($urandom_range(0, 8)) - 4;
      if (base > 16384) base = 16384;
      if (base < -16384) base = -16384;
      return q9sf_pkg::IN_W'(base);
    end
    return q9sf_pkg::IN_W'(base);
  endfunction

  always @(negedge clk) begin
    case (rx_mode)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_RANDOM: out_ch.ready <= ($urandom_range(0, 9) < 7);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else if (run_left != 0) begin
          run_left--;
          out_ch.ready <= 1'b1;
        end else begin
          stall_left = $urandom_range(1, 20);
          run_left   = $urandom_range(1, 8);
          out_ch.ready <= 1'b0;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    node_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected node word node=%0d shape=%0d", $time,
                 out_ch.node, out_ch.shape_value);
        error_count++;
      end else begin
        w = expected_words.pop_front();
        words_checked++;
        if (w.shape_value == q9sf_pkg::OUT_MAX || w.shape_value == q9sf_pkg::OUT_MIN ||
            w.d_dcsi == q9sf_pkg::OUT_MAX || w.d_dcsi == q9sf_pkg::OUT_MIN ||
            w.d_deta == q9sf_pkg::OUT_MAX || w.d_deta == q9sf_pkg::OUT_MIN)
          saturated_words++;
        if (out_ch.node !== w.node) begin
          $display("%0t: node expected %0d got %0d", $time, w.node, out_ch.node);
          error_count++;
        end
        if (out_ch.shape_value !== w.shape_value) begin
          $display("%0t: node %0d shape_value expected %0d got %0d", $time, w.node,
                   w.shape_value, out_ch.shape_value);
          error_count++;
        end
        if (out_ch.d_dcsi !== w.d_dcsi) begin
          $display("%0t: node %0d d_dcsi expected %0d got %0d", $time, w.node,
                   w.d_dcsi, out_ch.d_dcsi);
          error_count++;
        end
        if (out_ch.d_deta !== w.d_deta) begin
          $display("%0t: node %0d d_deta expected %0d got %0d", $time, w.node,
                   w.d_deta, out_ch.d_deta);
          error_count++;
        end
        if (out_ch.last !== w.last) begin
          $display("%0t: node %0d last expected %0b got %0b", $time, w.node,
                   w.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  task automatic test_node_points();
    rx_mode     = RX_OPEN;
    sender_gaps = 1'b0;
    // nine nodes (one shape value one, rest zero), then interior points
    send_point(-COORD_ONE, -COORD_ONE);
    send_point( COORD_ONE, -COORD_ONE);
    send_point( COORD_ONE,  COORD_ONE);
    send_point(-COORD_ONE,  COORD_ONE);
    send_point(16'sd0,     -COORD_ONE);
    send_point( COORD_ONE,  16'sd0);
    send_point(16'sd0,      COORD_ONE);
    send_point(-COORD_ONE,  16'sd0);
    send_point(16'sd0,      16'sd0);
    send_point( COORD_HALF, -COORD_HALF);
    send_point(-COORD_HALF,  COORD_HALF);
    send_point(16'sd1, -16'sd1);
    send_point(16'sd16383, -16'sd16383);
    // just outside the element, then corners, edges of the 16-bit range
    send_point(-16'sd16385, 16'sd16385);
    send_point(COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX);
    send_point(COORD_MAX, COORD_MIN);
    send_point(COORD_MAX, 16'sd0);
    send_point(16'sd0, COORD_MIN);
  endtask

  task automatic test_random_interior();
    rx_mode     = RX_RANDOM;
    sender_gaps = 1'b1;
    repeat (150) send_point(interior_coord(), interior_coord());
    rx_mode = RX_OPEN;
    repeat (150) send_point(interior_coord(), interior_coord());
  endtask

  task automatic test_full_range();
    rx_mode     = RX_RANDOM;
    sender_gaps = 1'b1;
    repeat (60) send_point(q9sf_pkg::IN_W'($urandom), q9sf_pkg::IN_W'($urandom));
    repeat (40) send_point(q9sf_pkg::IN_W'($urandom), interior_coord());
  endtask

  task automatic test_long_stalls();
    rx_mode     = RX_LONG_STALL;
    sender_gaps = 1'b0;
    repeat (30) send_point(interior_coord(), interior_coord());
    sender_gaps = 1'b1;
    repeat (20) send_point(q9sf_pkg::IN_W'($urandom), q9sf_pkg::IN_W'($urandom));
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.csi       = '0;
    in_ch.eta       = '0;
    out_ch.ready    = 1'b1;
    error_count     = 0;
    points_sent     = 0;
    words_checked   = 0;
    saturated_words = 0;
    burst_left      = 0;
    sender_gaps     = 1'b0;
    rx_mode         = RX_OPEN;
    stall_left      = 0;
    run_left        = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_node_points();
    test_random_interior();
    test_full_range();
    test_long_stalls();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    rx_mode = RX_RANDOM;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d node words from %0d points (%0d words hit a clamp)",
             words_checked, points_sent, saturated_words);
    $display("covered node points, interior and full-range coordinates, long stalls");
    if (error_count == 0) begin
      $display("quad9_shape_function_eval_unit regression: pass");
    end else begin
      $display("quad9_shape_function_eval_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("quad9_shape_function_eval_unit regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/q9sf_pkg.sv
rtl/core/q9sf_if.sv
rtl/core/q9sf_lagrange.sv
rtl/core/q9sf_round_sat.sv
rtl/core/quad9_shape_function_eval_unit.sv
rtl/core/q9sf_checker.sv
test/tb_quad9_shape_function_eval_unit.sv
